### hw/rtl/pwlh_pkg.sv
// Shared types, constants and codes of the task wait latency histogram.
`timescale 1ns / 1ps

package pwlh_pkg;

  localparam int TASK_W    = 22;
  localparam int TIME_W    = 64;
  localparam int LAT_W     = 55;
  localparam int EDGE_W    = 24;
  localparam int BKT_W     = 3;
  localparam int CNT_OUT_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int NBUCKETS  = 7;
  localparam int NEDGES    = 6;
  localparam int NS_PER_US = 1000;

  localparam int STAMP_SLOTS_DEF = 64;
  localparam int HIST_SLOTS_DEF  = 64;
  localparam int COUNT_BITS_DEF  = 32;

  localparam logic [EDGE_W-1:0] EDGE_RESET [NEDGES] = '{
    24'd5, 24'd10, 24'd20, 24'd50, 24'd100, 24'd1000
  };

  typedef enum logic [1:0] {
    MODE_WAKE   = 2'd0,
    MODE_SWITCH = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_STAMPED  = 3'd0,
    ST_COUNTED  = 3'd1,
    ST_MISSED   = 3'd2,
    ST_FULL     = 3'd3,
    ST_READOUT  = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TASK_W-1:0] task_id;
    logic              task_runnable;
    logic [TASK_W-1:0] incoming_id;
    logic [TIME_W-1:0] now_ns;
  } pwlh_in_t;

  typedef struct packed {
    status_t              status;
    logic [TASK_W-1:0]    out_task;
    logic [LAT_W-1:0]     latency_us;
    logic [BKT_W-1:0]     bucket;
    logic [CNT_OUT_W-1:0] count;
    logic                 last;
  } pwlh_out_t;

endpackage

### hw/rtl/pwlh_div1000.sv
// Divider of a 64-bit nanosecond span by 1000, one 16-bit quotient digit at a time.
`timescale 1ns / 1ps

module pwlh_div1000 import pwlh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  output logic              busy,
  output logic [TIME_W-1:0] quot
);

  // long division in 16-bit digits; each partial value v < 1000 * 2^16 < 2^26,
  // so floor(v / 1000) = (v * RECIP) >> RSH exactly
  localparam int DIG_W  = 16;
  localparam int NDIG   = TIME_W / DIG_W;
  localparam int REM_W  = $clog2(NS_PER_US);
  localparam int V_W    = REM_W + DIG_W;
  localparam int RSH    = V_W + REM_W;
  localparam int RCP_W  = V_W + 1;
  localparam int PROD_W = V_W + RCP_W;
  localparam int CNT_W  = $clog2(NDIG);
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << RSH) + 64'(NS_PER_US) - 64'd1) / 64'(NS_PER_US));

  logic [REM_W-1:0]  rem_r;
  logic [TIME_W-1:0] dvd_r;
  logic [DIG_W-1:0]  q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              ph_r;
  logic [V_W-1:0]    v;
  logic [PROD_W-1:0] prod;
  logic [V_W-1:0]    qk;

  assign v    = {rem_r, dvd_r[TIME_W-1 -: DIG_W]};
  assign prod = PROD_W'(v) * PROD_W'(RECIP);
  assign qk   = V_W'(q_r) * V_W'(NS_PER_US);

  // first phase of a digit forms the quotient digit, second phase the remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      ph_r   <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      dvd_r  <= dividend;
    end else if (busy_r) begin
      if (!ph_r) begin
        q_r  <= prod[RSH +: DIG_W];
        ph_r <= 1'b1;
      end else begin
        rem_r <= REM_W'(v - qk);
        dvd_r <= {dvd_r[TIME_W-DIG_W-1:0], q_r};
        ph_r  <= 1'b0;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NDIG - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign busy = busy_r;
  assign quot = dvd_r;

endmodule

### hw/rtl/per_task_wait_latency_histogram.sv
// Top level: per-task wait latency histogram built on a stamp memory and a histogram memory.
// A read gives 7 readouts; on a switch the divide runs beside the histogram sweep.
//   A switch with a runnable task restamps it before the lookup of the incoming task.
// Throughput: one item at a time, next accepted once its last result is issued; sweeps
//   read one entry a cycle; output stalls hold an item longer.
// Reset: synchronous, active low; valid bits and edges reset at once, no memory clearing pass.
`timescale 1ns / 1ps

module per_task_wait_latency_histogram import pwlh_pkg::*; #(
  parameter int STAMP_SLOTS = STAMP_SLOTS_DEF,
  parameter int HIST_SLOTS  = HIST_SLOTS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pwlh_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pwlh_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [EDGE_W-1:0]    cfg_data
);

  localparam int SAW     = $clog2(STAMP_SLOTS);
  localparam int HAW     = $clog2(HIST_SLOTS);
  localparam int IW      = (SAW > HAW) ? SAW : HAW;
  localparam int CW      = IW + 1;
  localparam int SROW_W  = TASK_W + TIME_W;
  localparam int HCNT_W  = NBUCKETS * COUNT_BITS;
  localparam int HROW_W  = TASK_W + HCNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_POST, S_DIVW, S_BKT, S_HUPD, S_RDOUT
  } state_t;

  // what the current sweep is looking up
  typedef enum logic [1:0] {
    PH_STAMP, PH_INC, PH_HIST, PH_READ
  } phase_t;

  typedef logic [NBUCKETS-1:0][COUNT_BITS-1:0] cnt_row_t;

  state_t            state_r;
  phase_t            phase_r;
  pwlh_in_t          item_r;
  logic [TASK_W-1:0] key_r;

  logic [EDGE_W-1:0] edge_r [NEDGES];

  // memories and their registered read data
  logic [SROW_W-1:0] stamp_mem [STAMP_SLOTS];
  logic [HROW_W-1:0] hist_mem  [HIST_SLOTS];
  logic [SROW_W-1:0] stamp_q;
  logic [HROW_W-1:0] hist_q;
  logic [STAMP_SLOTS-1:0] stamp_vld_r;
  logic [HIST_SLOTS-1:0]  hist_vld_r;

  // sweep control
  logic          scan_hist_r;
  logic [CW-1:0] iss_r;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic          free_r;
  logic [IW-1:0] free_idx_r;
  logic [TIME_W-1:0] time_cap_r;
  cnt_row_t      row_cnt_r;
  logic [CW-1:0] scan_lim;

  logic [LAT_W-1:0] lat_r;
  logic [BKT_W-1:0] bkt_r;
  logic [BKT_W-1:0] bkt_nxt;
  logic [BKT_W-1:0] rd_b_r;

  logic            out_valid_r;
  pwlh_out_t       out_data_r;
  logic            can_emit;

  logic              div_start;
  logic              div_busy;
  logic [TIME_W-1:0] div_quot;

  logic              stamp_we;
  logic [SAW-1:0]    stamp_waddr;
  logic              hist_we;
  logic [HAW-1:0]    hist_waddr;
  cnt_row_t          hist_wcnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [63:0]       cnt_ext;
  logic [63:0]       rd_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign can_emit  = !out_valid_r || out_ready;
  assign scan_lim  = scan_hist_r ? CW'(HIST_SLOTS) : CW'(STAMP_SLOTS);

  // bucket select: first edge in order that exceeds the latency
  always_comb begin
    bkt_nxt = BKT_W'(NEDGES);
    for (int b = NEDGES - 1; b >= 0; b--) begin
      if (lat_r < LAT_W'(edge_r[b])) bkt_nxt = BKT_W'(b);
    end
  end

  // stamp write: overwrite on hit, else take first free slot
  assign stamp_we    = (state_r == S_POST) && (phase_r == PH_STAMP) && can_emit &&
                       (hit_r || free_r);
  assign stamp_waddr = hit_r ? hit_idx_r[SAW-1:0] : free_idx_r[SAW-1:0];

  // histogram row update, new rows start cleared
  assign new_cnt = row_cnt_r[bkt_r] + COUNT_BITS'(1);
  always_comb begin
    if (hit_r) begin
      hist_wcnt = row_cnt_r;
      hist_wcnt[bkt_r] = new_cnt;
    end else begin
      hist_wcnt = '0;
      hist_wcnt[bkt_r] = COUNT_BITS'(1);
    end
  end
  assign hist_we    = (state_r == S_HUPD) && can_emit && (hit_r || free_r);
  assign hist_waddr = hit_r ? hit_idx_r[HAW-1:0] : free_idx_r[HAW-1:0];
  assign cnt_ext    = 64'(hist_wcnt[bkt_r]);
  assign rd_ext     = 64'(row_cnt_r[rd_b_r]);

  assign div_start = (state_r == S_POST) && (phase_r == PH_INC) && hit_r && can_emit;

  pwlh_div1000 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (item_r.now_ns - time_cap_r),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= {key_r, item_r.now_ns};
    end
    stamp_q <= stamp_mem[iss_r[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= {key_r, hist_wcnt};
    end
    hist_q <= hist_mem[iss_r[HAW-1:0]];
  end

  // configuration: writes beyond the edge list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NEDGES; i++) edge_r[i] <= EDGE_RESET[i];
    end else if (cfg_valid) begin
      for (int i = 0; i < NEDGES; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) edge_r[i] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_STAMP;
      out_valid_r <= 1'b0;
      stamp_vld_r <= '0;
      hist_vld_r  <= '0;
      cmp_vld_r   <= 1'b0;
      iss_r       <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      scan_hist_r <= 1'b0;
    end else begin
      if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r      <= in_data;
            iss_r       <= '0;
            cmp_vld_r   <= 1'b0;
            hit_r       <= 1'b0;
            free_r      <= 1'b0;
            scan_hist_r <= 1'b0;
            state_r     <= S_SCAN;
            case (mode_t'(in_data.mode))
              MODE_WAKE: begin
                key_r   <= in_data.task_id;
                phase_r <= PH_STAMP;
              end
              MODE_SWITCH: begin
                if (in_data.task_runnable) begin
                  key_r   <= in_data.task_id;
                  phase_r <= PH_STAMP;
                end else begin
                  key_r   <= in_data.incoming_id;
                  phase_r <= PH_INC;
                end
              end
              MODE_READ: begin
                key_r       <= in_data.task_id;
                phase_r     <= PH_READ;
                scan_hist_r <= 1'b1;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end

        // one read issued and one entry compared per cycle
        S_SCAN: begin
          if (iss_r < scan_lim) begin
            iss_r     <= iss_r + CW'(1);
            cmp_vld_r <= 1'b1;
            cmp_idx_r <= iss_r[IW-1:0];
          end else begin
            cmp_vld_r <= 1'b0;
          end
          if (cmp_vld_r) begin
            if (scan_hist_r) begin
              if (hist_vld_r[cmp_idx_r[HAW-1:0]] &&
                  hist_q[HROW_W-1 -: TASK_W] == key_r) begin
                hit_r     <= 1'b1;
                hit_idx_r <= cmp_idx_r;
                row_cnt_r <= cnt_row_t'(hist_q[HCNT_W-1:0]);
              end
              if (!hist_vld_r[cmp_idx_r[HAW-1:0]] && !free_r) begin
                free_r     <= 1'b1;
                free_idx_r <= cmp_idx_r;
              end
            end else begin
              if (stamp_vld_r[cmp_idx_r[SAW-1:0]] &&
                  stamp_q[SROW_W-1 -: TASK_W] == key_r) begin
                hit_r      <= 1'b1;
                hit_idx_r  <= cmp_idx_r;
                time_cap_r <= stamp_q[TIME_W-1:0];
              end
              if (!stamp_vld_r[cmp_idx_r[SAW-1:0]] && !free_r) begin
                free_r     <= 1'b1;
                free_idx_r <= cmp_idx_r;
              end
            end
          end
          if (iss_r == scan_lim && !cmp_vld_r) state_r <= S_POST;
        end

        S_POST: begin
          case (phase_r)
            PH_STAMP: begin
              if (can_emit) begin
                if (stamp_we) stamp_vld_r[stamp_waddr] <= 1'b1;
                out_valid_r <= 1'b1;
                out_data_r  <= '{status: (hit_r || free_r) ? ST_STAMPED : ST_FULL,
                                 out_task: key_r, latency_us: '0, bucket: '0,
                                 count: '0,
                                 last: (item_r.mode != MODE_SWITCH)};
                if (item_r.mode == MODE_SWITCH) begin
                  key_r     <= item_r.incoming_id;
                  phase_r   <= PH_INC;
                  iss_r     <= '0;
                  cmp_vld_r <= 1'b0;
                  hit_r     <= 1'b0;
                  free_r    <= 1'b0;
                  state_r   <= S_SCAN;
                end else begin
                  state_r <= S_IDLE;
                end
              end
            end
            PH_INC: begin
              if (!hit_r) begin
                if (can_emit) begin
                  out_valid_r <= 1'b1;
                  out_data_r  <= '{status: ST_MISSED, out_task: key_r, latency_us: '0,
                                   bucket: '0, count: '0, last: 1'b1};
                  state_r     <= S_IDLE;
                end
              end else if (can_emit) begin
                // stamp freed, divide runs beside the histogram sweep
                stamp_vld_r[hit_idx_r[SAW-1:0]] <= 1'b0;
                phase_r     <= PH_HIST;
                scan_hist_r <= 1'b1;
                iss_r       <= '0;
                cmp_vld_r   <= 1'b0;
                hit_r       <= 1'b0;
                free_r      <= 1'b0;
                state_r     <= S_SCAN;
              end
            end
            PH_HIST: state_r <= S_DIVW;
            default: begin
              if (!hit_r) begin
                if (can_emit) begin
                  out_valid_r <= 1'b1;
                  out_data_r  <= '{status: ST_NOTFOUND, out_task: key_r, latency_us: '0,
                                   bucket: '0, count: '0, last: 1'b1};
                  state_r     <= S_IDLE;
                end
              end else begin
                rd_b_r  <= '0;
                state_r <= S_RDOUT;
              end
            end
          endcase
        end

        S_DIVW: begin
          if (!div_busy) begin
            lat_r   <= div_quot[LAT_W-1:0];
            state_r <= S_BKT;
          end
        end

        S_BKT: begin
          bkt_r   <= bkt_nxt;
          state_r <= S_HUPD;
        end

        S_HUPD: begin
          if (can_emit) begin
            if (!hit_r && free_r) hist_vld_r[free_idx_r[HAW-1:0]] <= 1'b1;
            out_valid_r <= 1'b1;
            out_data_r  <= '{status: (hit_r || free_r) ? ST_COUNTED : ST_FULL,
                             out_task: key_r, latency_us: lat_r, bucket: bkt_r,
                             count: (hit_r || free_r) ? cnt_ext[CNT_OUT_W-1:0] : '0,
                             last: 1'b1};
            state_r     <= S_IDLE;
          end
        end

        S_RDOUT: begin
          if (can_emit) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{status: ST_READOUT, out_task: key_r, latency_us: '0,
                             bucket: rd_b_r, count: rd_ext[CNT_OUT_W-1:0],
                             last: (rd_b_r == BKT_W'(NBUCKETS - 1))};
            if (rd_b_r == BKT_W'(NBUCKETS - 1)) begin
              state_r <= S_IDLE;
            end else begin
              rd_b_r <= rd_b_r + BKT_W'(1);
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### dv/tb_per_task_wait_latency_histogram.sv
// Testbench for the per-task wait latency histogram: directed and random events, scoreboard.
`timescale 1ns / 1ps

module tb_per_task_wait_latency_histogram;
  import pwlh_pkg::*;

  localparam int SLOTS = 64;
  localparam int LIMIT_CYCLES = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pwlh_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pwlh_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [EDGE_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  per_task_wait_latency_histogram u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: its own copy of the edges and both tables
  logic [EDGE_W-1:0] bound [NEDGES];
  logic sv_ok [SLOTS];
  logic [TASK_W-1:0] sv_task [SLOTS];
  logic [TIME_W-1:0] sv_time [SLOTS];
  logic hv_ok [SLOTS];
  logic [TASK_W-1:0] hv_task [SLOTS];
  logic [CNT_OUT_W-1:0] hv_cnt [SLOTS][NBUCKETS];

  pwlh_in_t  event_q [$];
  pwlh_out_t expected_q [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int unsigned cycle_cnt = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0d: %s", cycle_cnt, what);
    errors++;
  endtask

  function automatic int stamp_slot(input logic [TASK_W-1:0] t);
    for (int i = 0; i < SLOTS; i++) if (sv_ok[i] && sv_task[i] == t) return i;
    return -1;
  endfunction

  function automatic int hist_slot(input logic [TASK_W-1:0] t);
    for (int i = 0; i < SLOTS; i++) if (hv_ok[i] && hv_task[i] == t) return i;
    return -1;
  endfunction

  function automatic pwlh_out_t mk(input status_t s, input logic [TASK_W-1:0] t,
                                   input logic [LAT_W-1:0] l, input int b,
                                   input logic [CNT_OUT_W-1:0] c);
    pwlh_out_t r;
    r.status = s; r.out_task = t; r.latency_us = l;
    r.bucket = b[BKT_W-1:0]; r.count = c; r.last = 1'b0;
    return r;
  endfunction

  // Store a stamp; returns the status to report
  function automatic status_t stamp_task(input logic [TASK_W-1:0] t,
                                          input logic [TIME_W-1:0] now);
    int i;
    i = stamp_slot(t);
    if (i < 0) begin
      for (i = 0; i < SLOTS; i++) if (!sv_ok[i]) break;
      if (i >= SLOTS) return ST_FULL;
      sv_ok[i] = 1'b1;
      sv_task[i] = t;
    end
    sv_time[i] = now;
    return ST_STAMPED;
  endfunction

  task automatic predict_event(input pwlh_in_t ev);
    pwlh_out_t res [$];
    int s, h, b;
    logic [TIME_W-1:0] lat;
    case (mode_t'(ev.mode))
      MODE_WAKE: res.push_back(mk(stamp_task(ev.task_id, ev.now_ns), ev.task_id, '0, 0, '0));
      MODE_SWITCH: begin
        if (ev.task_runnable)
          res.push_back(mk(stamp_task(ev.task_id, ev.now_ns), ev.task_id, '0, 0, '0));
        s = stamp_slot(ev.incoming_id);
        if (s < 0) begin
          res.push_back(mk(ST_MISSED, ev.incoming_id, '0, 0, '0));
        end else begin
          lat = (ev.now_ns - sv_time[s]) / NS_PER_US;
          b = NEDGES;
          for (int k = NEDGES - 1; k >= 0; k--) if (lat < {40'd0, bound[k]}) b = k;
          sv_ok[s] = 1'b0;
          h = hist_slot(ev.incoming_id);
          if (h < 0) begin
            for (h = 0; h < SLOTS; h++) if (!hv_ok[h]) break;
            if (h < SLOTS) begin
              hv_ok[h] = 1'b1;
              hv_task[h] = ev.incoming_id;
              for (int k = 0; k < NBUCKETS; k++) hv_cnt[h][k] = '0;
            end else h = -1;
          end
          if (h < 0) begin
            res.push_back(mk(ST_FULL, ev.incoming_id, lat[LAT_W-1:0], b, '0));
          end else begin
            hv_cnt[h][b] = hv_cnt[h][b] + CNT_OUT_W'(1);
            res.push_back(mk(ST_COUNTED, ev.incoming_id, lat[LAT_W-1:0], b, hv_cnt[h][b]));
          end
        end
      end
      MODE_READ: begin
        h = hist_slot(ev.task_id);
        if (h < 0) res.push_back(mk(ST_NOTFOUND, ev.task_id, '0, 0, '0));
        else for (int k = 0; k < NBUCKETS; k++)
          res.push_back(mk(ST_READOUT, ev.task_id, '0, k, hv_cnt[h][k]));
      end
      default: ;  // mode 3 leaves everything untouched
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_q.push_back(res[i]);
  endtask

  // Driver: next event from the queue, random gaps, valid held until transfer
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n) begin
      if (in_valid && in_ready) predict_event(in_data);
      if (!in_valid || in_ready) begin
        if (event_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= event_q.pop_front();
          in_valid <= 1'b1;
        end else in_valid <= 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    pwlh_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) report_mismatch("result with nothing expected");
      else begin
        e = expected_q.pop_front();
        if (out_data.status !== e.status) report_mismatch($sformatf("status %0d exp %0d",
          out_data.status, e.status));
        if (out_data.out_task !== e.out_task) report_mismatch($sformatf("task %0h exp %0h",
          out_data.out_task, e.out_task));
        if (out_data.latency_us !== e.latency_us) report_mismatch($sformatf(
          "latency %0d exp %0d", out_data.latency_us, e.latency_us));
        if (out_data.bucket !== e.bucket) report_mismatch($sformatf("bucket %0d exp %0d",
          out_data.bucket, e.bucket));
        if (out_data.count !== e.count) report_mismatch($sformatf("count %0d exp %0d",
          out_data.count, e.count));
        if (out_data.last !== e.last) report_mismatch($sformatf("last %0b exp %0b",
          out_data.last, e.last));
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (event_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (2 * SLOTS + SLOTS + 40) @(posedge clk);
  endtask

  // one write per call; valid drops for a cycle between writes
  task automatic write_edge(input int idx, input logic [EDGE_W-1:0] v);
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    bound[idx] = v;
  endtask

  function automatic pwlh_in_t ev_make(input mode_t m, input logic [TASK_W-1:0] t,
                                       input logic r, input logic [TASK_W-1:0] inc,
                                       input logic [TIME_W-1:0] now);
    pwlh_in_t x;
    x.mode = m; x.task_id = t; x.task_runnable = r; x.incoming_id = inc; x.now_ns = now;
    return x;
  endfunction

  logic [TIME_W-1:0] clock_ns = 64'd1000;

  // Random event from a small task pool so lookups hit; pool width picks table pressure
  task automatic queue_random(input int pool);
    logic [TASK_W-1:0] a, b;
    int r;
    a = (pool > 0) ? TASK_W'($urandom_range(pool - 1)) : TASK_W'($urandom);
    b = (pool > 0) ? TASK_W'($urandom_range(pool - 1)) : TASK_W'($urandom);
    r = $urandom_range(99);
    clock_ns = clock_ns + {$urandom_range(3), $urandom_range(2000000)};
    if (r < 40) event_q.push_back(ev_make(MODE_WAKE, a, 1'($urandom), TASK_W'($urandom),
                                          clock_ns));
    else if (r < 80) event_q.push_back(ev_make(MODE_SWITCH, a, 1'($urandom), b, clock_ns));
    else if (r < 92) event_q.push_back(ev_make(MODE_READ, a, 1'($urandom),
                                               TASK_W'($urandom), clock_ns));
    else if (r < 96) event_q.push_back(ev_make(mode_t'(r[1:0]), TASK_W'($urandom),
                                               1'($urandom), TASK_W'($urandom),
                                               {$urandom, $urandom}));
    else event_q.push_back(ev_make(MODE_NONE, a, 1'($urandom), b, clock_ns));
  endtask

  initial begin
    for (int k = 0; k < NEDGES; k++) bound[k] = EDGE_RESET[k];
    for (int i = 0; i < SLOTS; i++) begin
      sv_ok[i] = 1'b0;
      hv_ok[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each mode, extremes, overwrite, backward time, missing stamp
    event_q.push_back(ev_make(MODE_READ, 22'h3FFFFF, 1'b0, 0, 0));          // unknown task
    event_q.push_back(ev_make(MODE_SWITCH, 0, 1'b0, 22'h3FFFFF, 0));        // no stamp
    event_q.push_back(ev_make(MODE_WAKE, 22'h3FFFFF, 1'b0, 0, 64'd100));
    event_q.push_back(ev_make(MODE_WAKE, 22'h3FFFFF, 1'b1, 22'h3FFFFF, 64'd2000)); // overwrite
    event_q.push_back(ev_make(MODE_SWITCH, 0, 1'b1, 22'h3FFFFF, 64'd9000)); // restamp task 0
    event_q.push_back(ev_make(MODE_SWITCH, 5, 1'b0, 0, 64'd1000));          // time backwards
    event_q.push_back(ev_make(MODE_WAKE, 7, 1'b0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
    event_q.push_back(ev_make(MODE_SWITCH, 7, 1'b0, 7, 64'hFFFF_FFFF_FFFF_FFFF)); // zero wait
    event_q.push_back(ev_make(MODE_NONE, 22'h3FFFFF, 1'b1, 22'h3FFFFF, '1));
    event_q.push_back(ev_make(MODE_READ, 22'h3FFFFF, 1'b0, 0, 0));
    event_q.push_back(ev_make(MODE_READ, 0, 1'b0, 0, 0));
    for (int k = 0; k < 7; k++) begin
      event_q.push_back(ev_make(MODE_WAKE, 9, 1'b0, 0, 64'd0));
      event_q.push_back(ev_make(MODE_SWITCH, 1, 1'b0, 9,
                                64'd1000 * (64'd1 << (2 * k + 1))));  // spread over buckets
    end
    send_idle_pct = 38; recv_idle_pct = 48;
    wait_drained();

    // Unordered extremes, then zeroes, then ordered maxima
    for (int k = 0; k < NEDGES; k++) write_edge(k, (k % 2) ? 24'hFFFFFF : 24'd3);
    for (int i = 0; i < 50; i++) queue_random(16);
    wait_drained();
    for (int k = 0; k < NEDGES; k++) write_edge(k, 24'd0);
    // Fill the stamp and hist tables to see drops
    for (int i = 0; i < 66; i++)
      event_q.push_back(ev_make(MODE_WAKE, TASK_W'(22'h100 + i), 1'b0, 0, 64'd5));
    for (int i = 0; i < 66; i++)
      event_q.push_back(ev_make(MODE_SWITCH, 0, 1'b1, TASK_W'(22'h100 + i), 64'd90000));
    send_idle_pct = 48; recv_idle_pct = 38;
    wait_drained();
    for (int k = 0; k < NEDGES; k++) write_edge(k, EDGE_W'(24'hFFFFFA + k));
    for (int i = 0; i < 25; i++) queue_random(0);
    for (int i = 0; i < 25; i++) queue_random(8);
    wait_drained();
    for (int k = 0; k < NEDGES; k++) write_edge(k, EDGE_W'(EDGE_RESET[k] * 100));
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 50; i++) queue_random(12);
    wait_drained();

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
